// ===== rtl/core/gkr_pkg.sv =====
// ----------------------------------------------------------------------------
// gkr_pkg
// shared types and constants for the gaussian kernel regression block
// ----------------------------------------------------------------------------
package gkr_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 64;
	localparam logic [31:0] INV_RESET = 32'd65536;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] sample_time;
		logic signed [31:0] sample_value;
		logic signed [31:0] query_time;
	} in_req_t;

	typedef struct packed {
		logic signed [31:0] smoothed_value;
		logic               no_weight;
	} out_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_DIFF,
		ST_SQ,
		ST_ARG,
		ST_EXP,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	// multiplier operand select for the shared unit
	typedef enum logic [2:0] {
		M_SQ, M_ARG_LO, M_ARG_HI, M_HORNER, M_SQR, M_WV
	} msel_t;

endpackage

// ===== rtl/core/gkr_ram.sv =====
// ----------------------------------------------------------------------------
// gkr_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module gkr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/core/gkr_div.sv =====
// ----------------------------------------------------------------------------
// gkr_div
// restoring divider, one quotient bit per cycle, unsigned 64 / 38
// ----------------------------------------------------------------------------
module gkr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [37:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [38:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [38:0] trial;
	logic [38:0] shifted;

	always_comb begin
		shifted = {rem_q[37:0], quo_q[63]};
		trial   = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[38]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done     = busy_q && (cnt_q == 7'd63);
	assign quotient = {quo_q[62:0], ~trial[38]};
endmodule

// ===== rtl/core/gaussian_kernel_regression.sv =====
// ----------------------------------------------------------------------------
// gaussian_kernel_regression
// nadaraya-watson smoother with a gaussian kernel, one shared multiplier
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  in       | input     | in_valid/stall   | command, sample_time, sample_value, query_time
//  out      | output    | out_valid/stall  | smoothed_value, no_weight
//  cfg      | input     | cfg_we           | inv_two_h_sq
//
//  clear and load are taken from idle; a query steps each stored sample through read,
//  diff, square, argument, exp and accumulate (exp is skipped when the argument
//  reaches 16 and the weight is zero), then the bit-serial divide and output load.
//  input stall is high while a query is in work; a finished query holds in its
//  last state while the previous result is still stalled. reset empties the
//  store and loads inv_two_h_sq with 1.0; the sample memories are not cleared.
// ----------------------------------------------------------------------------
module gaussian_kernel_regression
	import gkr_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_req_t    out_data,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

	state_t state_q, state_nx;

	logic [31:0]   inv_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   qtime_q;
	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [31:0]   t_rd, v_rd;

	// per-sample datapath registers
	logic [32:0]   absd_q;    // |t - s|
	logic [63:0]   sq_q;      // d^2
	logic [63:0]   arg_q;     // accumulated argument
	logic [2:0]    sub_q;     // micro step counter
	logic [3:0]    hstep_q;   // exp step: 0..3 horner, 4..11 squaring
	logic [31:0]   p_q;       // q2.30, <= 2^30
	logic [16:0]   w_q;
	logic signed [63:0] num_q;
	logic [37:0]   den_q;

	// shared multiplier: 33x33 unsigned, magnitudes
	logic [32:0]   ma, mb;
	logic [65:0]   mprod;
	logic [65:0]   mprod_q;
	assign mprod = ma * mb;

	logic          div_start, div_done;
	logic [63:0]   div_q;
	logic [63:0]   mag;
	logic          neg_q;
	out_req_t      out_q;
	logic          out_v_q;

	assign ram_we   = (state_q == ST_IDLE) && in_valid &&
		(cmd_t'(in_data.command) == CMD_LOAD) && (count_q < CW'(MAX_SAMPLES));
	assign ram_addr = (state_q == ST_IDLE) ? count_q[AW-1:0] : idx_q[AW-1:0];

	gkr_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_times (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(in_data.sample_time), .rdata(t_rd));
	gkr_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_values (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(in_data.sample_value), .rdata(v_rd));

	logic [32:0] dsum;
	assign dsum = {t_rd[31], t_rd} - {qtime_q[31], qtime_q};

	logic [31:0] y;       // a << 6, q2.30
	assign y = {2'b00, arg_q[23:0], 6'd0};

	// horner step divisors; divide by three through a reciprocal multiply
	logic [31:0] hdiv;
	always_comb begin
		case (hstep_q[1:0])
			2'd0:    hdiv = 32'(mprod_q[61:30] / 3'd4);
			2'd1:    hdiv = 32'((64'(mprod_q[61:30]) * 64'h0_AAAA_AAAB) >> 33);
			2'd2:    hdiv = 32'(mprod_q[61:30] / 3'd2);
			default: hdiv = mprod_q[61:30];
		endcase
	end

	// operand selection
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SQ:  begin ma = absd_q; mb = absd_q; end
			ST_ARG: begin
				ma = {1'b0, inv_q};
				mb = sub_q[0] ? {1'b0, sq_q[63:32]} : {1'b0, sq_q[31:0]};
			end
			ST_EXP: begin
				ma = {1'b0, p_q};
				mb = (hstep_q < 4'd4) ? {1'b0, y} : {1'b0, p_q};
			end
			ST_ACC: begin
				ma = {16'd0, w_q};
				mb = v_rd[31] ? (33'd0 - {v_rd[31], v_rd}) : {1'b0, v_rd};
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && cmd_t'(in_data.command) == CMD_QUERY) begin
				state_nx = (count_q == '0) ? ST_DIV : ST_RD;
			end
			ST_RD:   state_nx = ST_DIFF;
			ST_DIFF: state_nx = ST_SQ;
			ST_SQ:   if (sub_q == 3'd1) state_nx = ST_ARG;
			ST_ARG:  if (sub_q == 3'd3) state_nx = ST_EXP;
			ST_EXP:  if ((arg_q >= 64'(32'd16 << 16)) ||
					(hstep_q == 4'd11 && sub_q == 3'd1)) state_nx = ST_ACC;
			ST_ACC:  if (sub_q == 3'd1) begin
				state_nx = (idx_q + CW'(1) == count_q) ? ST_DIV : ST_RD;
			end
			ST_DIV:  if (div_done || (den_q == '0 && sub_q == 3'd1)) state_nx = ST_OUT;
			// wait for the output register to free up
			ST_OUT:  if (!out_v_q || !out_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			inv_q   <= INV_RESET;
			count_q <= '0;
			out_v_q <= 1'b0;
			sub_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) inv_q <= cfg_wdata;
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (state_q == ST_OUT && state_nx == ST_IDLE) out_v_q <= 1'b1;
			if (state_q == ST_IDLE && in_valid) begin
				if (cmd_t'(in_data.command) == CMD_CLEAR) count_q <= '0;
				if (ram_we) count_q <= count_q + CW'(1);
			end
			if (state_nx != state_q) sub_q <= '0;
			else if (state_q == ST_EXP && sub_q == 3'd1) sub_q <= '0;
			// hold in the divide so the divider starts only once
			else if (state_q == ST_DIV && sub_q == 3'd1) sub_q <= sub_q;
			else sub_q <= sub_q + 3'd1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mprod_q <= mprod;
		case (state_q)
			ST_IDLE: begin
				qtime_q <= in_data.query_time;
				idx_q   <= '0;
				num_q   <= '0;
				den_q   <= '0;
			end
			ST_DIFF: absd_q <= dsum[32] ? (33'd0 - dsum) : dsum;
			ST_SQ:   if (sub_q == 3'd1) sq_q <= mprod_q[63:0];
			ST_ARG: begin
				if (sub_q == 3'd1) arg_q <= 64'(mprod_q[63:32]);
				if (sub_q == 3'd2) arg_q <= arg_q + mprod_q[63:0];
				hstep_q <= '0;
				p_q     <= 32'h4000_0000;
			end
			// argument of 16 or more: weight is zero, skip the exponential
			ST_EXP: if (arg_q >= 64'(32'd16 << 16)) begin
				w_q <= '0;
			end else if (sub_q == 3'd1) begin
				hstep_q <= hstep_q + 4'd1;
				if (hstep_q < 4'd4) p_q <= 32'h4000_0000 - hdiv;
				else p_q <= 32'((mprod_q[63:0] + 64'h2000_0000) >> 30);
				if (hstep_q == 4'd11)
					w_q <= 17'((mprod_q[63:0] + 64'h2000_0000 + 64'(32'h2000) * 64'h4000_0000)
						>> 44);
			end
			ST_ACC: if (sub_q == 3'd1) begin
				num_q <= v_rd[31] ? num_q - $signed(mprod_q[63:0])
					: num_q + $signed(mprod_q[63:0]);
				den_q <= den_q + 38'(w_q);
				idx_q <= idx_q + CW'(1);
			end
			ST_DIV: if (sub_q == 3'd0) neg_q <= num_q[63];
			ST_OUT: if (!out_v_q || !out_stall) begin
				out_q.no_weight <= (den_q == '0);
				if (den_q == '0) out_q.smoothed_value <= '0;
				else if (neg_q) out_q.smoothed_value <=
					(div_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - div_q);
				else out_q.smoothed_value <=
					(div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
			end
			default: ;
		endcase
	end

	assign mag       = num_q[63] ? (64'd0 - num_q) : num_q;
	assign div_start = (state_q == ST_DIV) && (sub_q == 3'd0) && (den_q != '0);

	logic [63:0] div_res;
	gkr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(mag + 64'(den_q >> 1)), .divisor(den_q),
		.done(div_done), .quotient(div_res));
	always_ff @(posedge clk) if (div_done) div_q <= div_res;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES)) else $error("store overfilled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall) |=> (out_v_q && $stable(out_q)))
		else $error("result lost");
`endif
endmodule
